/* rtl/core/fcl_pkg.sv */
// Shared types for the full linear convolution block.
// Holds the action codes, the control state encoding and the cell control struct.
// No dependencies.
package fcl_pkg;

    localparam int CONV_BITS = 38;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SETTLE  = 5'b00010,
        ST_LAUNCH  = 5'b00100,
        ST_WAIT    = 5'b01000,
        ST_DELIVER = 5'b10000
    } state_t;

    // control broadcast to every tap cell
    typedef struct packed {
        logic shift;
        logic clear;
        logic wr_en;
    } cell_ctrl_t;

endpackage

/* rtl/core/fcl_cell.sv */
// One tap cell: coefficient, delay stage, product register and partial-sum stage.
// Depends on fcl_pkg.
module fcl_cell #(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W       = 5,
    parameter int CNT_W       = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fcl_pkg::cell_ctrl_t               ctrl,
    input  logic [IDX_W-1:0]                  wr_idx,
    input  logic signed [SAMPLE_BITS-1:0]     wr_data,
    input  logic [CNT_W-1:0]                  kernel_count,
    input  logic signed [SAMPLE_BITS-1:0]     d_in,
    output logic signed [SAMPLE_BITS-1:0]     d_out,
    input  logic                              sum_vld_in,
    input  logic [fcl_pkg::CONV_BITS-1:0]     sum_in,
    output logic                              sum_vld_out,
    output logic [fcl_pkg::CONV_BITS-1:0]     sum_out
);
    import fcl_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] tap_reg, tap_next;
    logic signed [SAMPLE_BITS-1:0] delay_reg, delay_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic [CONV_BITS-1:0]          sum_reg, sum_next;
    logic                          vld_reg;
    logic [CONV_BITS-1:0]          prod_ext;
    logic                          active;

    generate
        if (PROD_W >= CONV_BITS) begin : g_trunc
            assign prod_ext = prod_reg[CONV_BITS-1:0];
        end
        else begin : g_sext
            assign prod_ext = {{(CONV_BITS-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    endgenerate

    assign active = kernel_count > CNT_W'(IDX);

    always_comb
    begin
        tap_next = tap_reg;
        if (ctrl.wr_en && wr_idx == IDX_W'(IDX))
        begin
            tap_next = wr_data;
        end
        delay_next = delay_reg;
        if (ctrl.clear)
        begin
            delay_next = '0;
        end
        else if (ctrl.shift)
        begin
            delay_next = d_in;
        end
        prod_next = tap_reg * delay_reg;
        sum_next  = sum_reg;
        if (sum_vld_in)
        begin
            sum_next = sum_in + (active ? prod_ext : '0);
        end
    end

    // coefficient, product and sum are payload only
    always_ff @(posedge clk)
    begin
        tap_reg  <= tap_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            delay_reg <= delay_next;
            vld_reg   <= sum_vld_in;
        end
    end

    assign d_out       = delay_reg;
    assign sum_vld_out = vld_reg;
    assign sum_out     = sum_reg;

endmodule

/* rtl/core/full_linear_convolution.sv */
// Top level of the full linear convolution block: control sequencer and a row of tap cells.
// Depends on fcl_pkg and fcl_cell.
//
// Usage: items arrive on item_valid/item_ready with action, sample and restart_kernel.
// A load item writes the next kernel coefficient (restart_kernel begins a new kernel);
// loads past KERNEL_MAX taps are dropped. A sample item shifts into the delay line and
// gives one conv_out. A flush item gives kernel_count-1 tail outputs, the final one with
// last set, then clears the delay line. Results leave on result_valid/result_ready.
// Loads and unused actions give nothing.
// For each output the products settle in ST_SETTLE, ST_LAUNCH starts the partial sum, which
// walks the cell row one cell a cycle, then the output register is loaded; a flush repeats
// this for each tail output. Only one item is worked on at a time, so a sample item holds
// off the next one until its result is in the output register;
// a new item is taken while the last result still waits.
// If the receiver stalls, the next result waits at the end of the row until the output
// register frees. Reset clears the delay line, the kernel length and all valids;
// coefficients are undefined until loaded.
module full_linear_convolution #(
    parameter int KERNEL_MAX  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic [1:0]                           action,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic                                 restart_kernel,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [fcl_pkg::CONV_BITS-1:0] conv_out,
    output logic                                 last
);
    import fcl_pkg::*;

    localparam int IDX_W = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
    localparam int CNT_W = $clog2(KERNEL_MAX + 1);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       tail_reg, tail_next;
    logic                   flush_reg, flush_next;
    logic                   out_vld_reg, out_vld_next;
    logic [CONV_BITS-1:0]   conv_reg, conv_next;
    logic                   last_reg, last_next;

    cell_ctrl_t                     ctrl;
    logic [IDX_W-1:0]               wr_idx;
    logic                           start;
    logic                           out_free;
    logic signed [SAMPLE_BITS-1:0]  dly_chain [KERNEL_MAX+1];
    logic [CONV_BITS-1:0]           sum_chain [KERNEL_MAX+1];
    logic [KERNEL_MAX:0]            vld_chain;

    assign out_free   = !out_vld_reg || result_ready;
    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        tail_next    = tail_reg;
        flush_next   = flush_reg;
        out_vld_next = out_vld_reg && !result_ready;
        conv_next    = conv_reg;
        last_next    = last_reg;
        ctrl         = '0;
        wr_idx       = '0;
        start        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (action_t'(action))
                        ACT_LOAD:
                        begin
                            if (restart_kernel)
                            begin
                                ctrl.wr_en = 1'b1;
                                count_next = CNT_W'(1);
                            end
                            else if (count_reg < CNT_W'(KERNEL_MAX))
                            begin
                                ctrl.wr_en = 1'b1;
                                wr_idx     = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_SAMPLE:
                        begin
                            ctrl.shift = 1'b1;
                            flush_next = 1'b0;
                            state_next = ST_SETTLE;
                        end
                        ACT_FLUSH:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                ctrl.shift = 1'b1;
                                flush_next = 1'b1;
                                tail_next  = count_reg - CNT_W'(1);
                                state_next = ST_SETTLE;
                            end
                            else
                            begin
                                ctrl.clear = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                start      = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (vld_chain[KERNEL_MAX])
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    conv_next    = sum_chain[KERNEL_MAX];
                    last_next    = flush_reg && (tail_reg == CNT_W'(1));
                    if (flush_reg && tail_reg > CNT_W'(1))
                    begin
                        tail_next  = tail_reg - CNT_W'(1);
                        ctrl.shift = 1'b1;
                        state_next = ST_SETTLE;
                    end
                    else
                    begin
                        ctrl.clear = flush_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            tail_reg    <= '0;
            flush_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tail_reg    <= tail_next;
            flush_reg   <= flush_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_reg <= conv_next;
        last_reg <= last_next;
    end

    // only a sample item feeds the row; every flush shift takes a zero
    assign dly_chain[0] = (state_reg == ST_IDLE && action_t'(action) == ACT_SAMPLE) ?
                          sample : '0;
    assign sum_chain[0] = '0;
    assign vld_chain[0] = start;

    genvar i;
    generate
        for (i = 0; i < KERNEL_MAX; i++)
        begin : g_cell
            fcl_cell #(
                .IDX         (i),
                .SAMPLE_BITS (SAMPLE_BITS),
                .IDX_W       (IDX_W),
                .CNT_W       (CNT_W)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .wr_idx       (wr_idx),
                .wr_data      (sample),
                .kernel_count (count_reg),
                .d_in         (dly_chain[i]),
                .d_out        (dly_chain[i+1]),
                .sum_vld_in   (vld_chain[i]),
                .sum_in       (sum_chain[i]),
                .sum_vld_out  (vld_chain[i+1]),
                .sum_out      (sum_chain[i+1])
            );
        end
    endgenerate

    assign result_valid = out_vld_reg;
    assign conv_out     = conv_reg;
    assign last         = last_reg;

    // at most one partial sum in flight along the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(vld_chain[KERNEL_MAX:1]))
        else $error("more than one partial sum in the cell row");

    a_end_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        vld_chain[KERNEL_MAX] |-> state_reg == ST_WAIT)
        else $error("sum left the row outside the wait state");

    a_launch_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LAUNCH |-> vld_chain[KERNEL_MAX:1] == '0)
        else $error("launch while a sum is still in the row");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(KERNEL_MAX))
        else $error("kernel length beyond capacity");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for full_linear_convolution: kernel loads, sample and flush streams.
// Holds its own FIR predictor and a queue of expected outputs; needs only fcl_pkg and the RTL.
module tb_top;
    import fcl_pkg::*;

    localparam int KMAX = 32;
    localparam int SBITS = 16;

    typedef struct {
        logic signed [CONV_BITS-1:0] conv;
        logic                        last;
    } conv_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        item_valid = 1'b0;
    logic                        item_ready;
    logic [1:0]                  action = ACT_NONE;
    logic signed [SBITS-1:0]     sample = '0;
    logic                        restart_kernel = 1'b0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    logic signed [CONV_BITS-1:0] conv_out;
    logic                        last;

    // predictor state
    logic signed [SBITS-1:0] coeffs [KMAX];
    logic signed [SBITS-1:0] history [KMAX] = '{default: '0};
    int unsigned             coeff_count = 0;
    conv_result_t            expected_outputs [$];

    int mismatches = 0;
    bit idle_on = 1'b1;
    int stall_left = 0;

    full_linear_convolution #(
        .KERNEL_MAX  (KMAX),
        .SAMPLE_BITS (SBITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .action         (action),
        .sample         (sample),
        .restart_kernel (restart_kernel),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .conv_out       (conv_out),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic void shift_history(logic signed [SBITS-1:0] x);
        for (int i = KMAX - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = x;
    endfunction

    function automatic logic signed [CONV_BITS-1:0] fir_output();
        logic signed [CONV_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < coeff_count; i++)
            acc = acc + coeffs[i] * history[i];
        return acc;
    endfunction

    function automatic void predict_outputs(action_t act, logic signed [SBITS-1:0] x, logic rs);
        conv_result_t res;
        int unsigned  tail;
        case (act)
            ACT_LOAD:
            begin
                if (rs)
                    coeff_count = 0;
                if (coeff_count < KMAX)
                begin
                    coeffs[coeff_count] = x;
                    coeff_count++;
                end
            end
            ACT_SAMPLE:
            begin
                shift_history(x);
                res.conv = fir_output();
                res.last = 1'b0;
                expected_outputs.push_back(res);
            end
            ACT_FLUSH:
            begin
                tail = (coeff_count > 1) ? coeff_count - 1 : 0;
                for (int k = 0; k < tail; k++)
                begin
                    shift_history('0);
                    res.conv = fir_output();
                    res.last = (k + 1 == tail);
                    expected_outputs.push_back(res);
                end
                for (int i = 0; i < KMAX; i++)
                    history[i] = '0;
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic send_item(action_t act, logic signed [SBITS-1:0] x, logic rs);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        action         <= act;
        sample         <= x;
        restart_kernel <= rs;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_outputs(act, x, rs);
    endtask

    // hold the sender until every expected output has come back
    task automatic wait_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_outputs.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [SBITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            default: return SBITS'($urandom);
        endcase
    endfunction

    // receiver: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // output checker
    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("unexpected output conv_out=%0d last=%0b", conv_out, last);
                mismatches++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (conv_out !== want.conv)
                begin
                    $error("conv_out: expected %0d, got %0d", want.conv, conv_out);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_empty_kernel();
        send_item(ACT_SAMPLE, 16'sd32767, 1'b0);
        send_item(ACT_FLUSH, '0, 1'b0);
        send_item(ACT_NONE, -16'sd1, 1'b1);
        wait_drain();
    endtask

    task automatic test_extremes();
        send_item(ACT_LOAD, -16'sd32768, 1'b1);
        send_item(ACT_LOAD, -16'sd32768, 1'b0);
        send_item(ACT_LOAD, 16'sd32767, 1'b0);
        send_item(ACT_SAMPLE, -16'sd32768, 1'b0);
        send_item(ACT_SAMPLE, -16'sd32768, 1'b0);
        send_item(ACT_SAMPLE, 16'sd32767, 1'b0);
        send_item(ACT_SAMPLE, '0, 1'b1);
        send_item(ACT_FLUSH, 16'sd32767, 1'b1);
        wait_drain();
    endtask

    // single tap: flush gives nothing but must still clear the delay line
    task automatic test_short_flush();
        send_item(ACT_LOAD, rand_sample(), 1'b1);
        send_item(ACT_SAMPLE, rand_sample(), 1'b0);
        send_item(ACT_FLUSH, '0, 1'b0);
        send_item(ACT_NONE, 16'sh5a5a, 1'b0);
        send_item(ACT_SAMPLE, rand_sample(), 1'b0);
        wait_drain();
    endtask

    // restart keeps the delay line contents
    task automatic test_restart_mid_stream();
        send_item(ACT_LOAD, rand_sample(), 1'b1);
        send_item(ACT_LOAD, rand_sample(), 1'b0);
        send_item(ACT_SAMPLE, rand_sample(), 1'b0);
        send_item(ACT_SAMPLE, rand_sample(), 1'b0);
        send_item(ACT_LOAD, rand_sample(), 1'b1);
        send_item(ACT_LOAD, rand_sample(), 1'b0);
        send_item(ACT_LOAD, rand_sample(), 1'b0);
        send_item(ACT_SAMPLE, rand_sample(), 1'b0);
        send_item(ACT_FLUSH, '0, 1'b0);
        wait_drain();
    endtask

    // one kernel, its samples, then a flush
    task automatic send_sequence(int unsigned taps, int unsigned n_samples, ref int sent);
        for (int i = 0; i < taps; i++)
            send_item(ACT_LOAD, rand_sample(), i == 0);
        for (int i = 0; i < n_samples; i++)
            send_item(ACT_SAMPLE, rand_sample(), 1'($urandom));
        send_item(ACT_FLUSH, rand_sample(), 1'($urandom));
        sent += taps + n_samples + 1;
    endtask

    task automatic test_random_sequences(int unsigned target);
        int sent;
        int seq_no;
        int unsigned taps;
        sent = 0;
        seq_no = 0;
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // noise, unused action included
                    send_item(action_t'($urandom_range(0, 3)), rand_sample(), 1'($urandom));
                    sent++;
                end
                1:
                begin
                    // broken: appended taps, stray samples or a bare flush
                    case ($urandom_range(0, 2))
                        0:       repeat ($urandom_range(1, 4)) send_item(ACT_LOAD, rand_sample(), 1'b0);
                        1:       repeat ($urandom_range(1, 6)) send_item(ACT_SAMPLE, rand_sample(), 1'b0);
                        default: send_item(ACT_FLUSH, rand_sample(), 1'b0);
                    endcase
                    sent += 2;
                end
                default:
                begin
                    // every eighth kernel is long (30 to 36 taps) and may run past capacity
                    taps = (seq_no % 8 == 3) ? $urandom_range(30, 36) : $urandom_range(1, 8);
                    send_sequence(taps, $urandom_range(1, 12), sent);
                    seq_no++;
                    if (seq_no == 5)
                        wait_drain();
                end
            endcase
        end
        wait_drain();
    endtask

    task automatic test_back_to_back();
        int sent;
        sent = 0;
        idle_on = 1'b0;
        send_sequence(4, 6, sent);
        send_sequence(32, 3, sent);
        send_sequence(2, 5, sent);
        wait_drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_kernel();
        test_extremes();
        test_short_flush();
        test_restart_mid_stream();
        test_random_sequences(140);
        test_back_to_back();
        // idle time so that a stray output is still caught by the checker
        repeat (4 * KMAX + 16) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
